// ===== design/utf_stream_validator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef UTF_STREAM_VALIDATOR_DEFINES_SVH
`define UTF_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define UTFSV_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTFSV_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/utfsv_pkg.sv =====
// Package: status codes, byte constants and widths for the UTF stream validator.
`timescale 1ns / 1ps
`default_nettype none
package utfsv_pkg;

  localparam int UNIT_W   = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_LEAD      = 3'd1,
    ST_MISSING_TRAIL = 3'd2,
    ST_OVERLONG      = 3'd3,
    ST_ABOVE_MAX     = 3'd4,
    ST_LONE_SURR     = 3'd5,
    ST_UNPAIRED_LEAD = 3'd6
  } status_t;

  // Overlong check armed by an E0 or F0 lead.
  typedef enum logic [1:0] {
    OVL_NONE    = 2'd0,
    OVL_NEED_20 = 2'd1,
    OVL_NEED_30 = 2'd2
  } ovl_t;

  localparam logic [7:0] LEAD_ASCII_END = 8'h80;
  localparam logic [7:0] LEAD_MIN       = 8'hC2;
  localparam logic [7:0] LEAD_3B        = 8'hE0;
  localparam logic [7:0] LEAD_4B        = 8'hF0;
  localparam logic [7:0] LEAD_MAX       = 8'hF4;
  localparam logic [7:0] OVL_LEAD_MASK  = 8'hEF;
  localparam logic [7:0] TRAIL_MASK     = 8'hC0;
  localparam logic [7:0] TRAIL_TAG      = 8'h80;
  localparam logic [7:0] BITS_20        = 8'h20;
  localparam logic [7:0] BITS_30        = 8'h30;

  localparam logic [15:0] SURR_FIRST = 16'hD800;
  localparam logic [15:0] SURR_LAST  = 16'hDFFF;

endpackage
`default_nettype wire

// ===== design/utf_stream_validator.sv =====
// Top level: UTF-8 / UTF-16 stream validator with input and result registers.
//
// Usage:
//   s_axis carries one code unit per request in tdata[15:0]; tlast marks the
//   final unit of a string. UTF-8 mode looks at tdata[7:0] only.
//   m_axis returns one result per unit: tdata[2:0] sticky status,
//   tdata[3] string_valid, tlast = string_done (copy of the input tlast).
//   cfg writes encoding_mode (0 UTF-8, 1 UTF-16); write only while idle.
// Timing: the result passes the input register, then the result register.
//   Throughput: one unit per cycle while the receiver takes results, set by
//   the single state-update stage between the two registers.
// The first error sticks until the unit marked last; that unit reports the
//   verdict and clears all per-string state.
// Reset (rst, synchronous) empties both registers, selects UTF-8 and clears
//   string state. When the receiver stalls, the result register holds and the
//   input register still takes one more request; after that tready drops.
`timescale 1ns / 1ps
`default_nettype none
module utf_stream_validator
  import utfsv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] code_unit
  input  wire logic                  s_axis_tlast,   // last_unit
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [2:0] status, [3] string_valid, [7:4] 0
  output logic                       m_axis_tlast,   // string_done
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data        // encoding_mode
);

  logic               encoding_mode;
  logic               in_valid;
  logic [UNIT_W-1:0]  in_unit;
  logic               in_last;
  logic               out_valid;
  status_t            out_status;
  logic               out_string_valid;
  logic               out_last;

  logic [1:0]  trails_pending,   trails_pending_next;
  ovl_t        overlong_mask,    overlong_mask_next;
  logic        range_check_armed, range_check_armed_next;
  logic        expect_low_surrogate, expect_low_surrogate_next;
  status_t     sticky_error,     sticky_error_next;
  status_t     result_status;

  logic        advance;
  logic [7:0]  b;
  logic        is_low;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign b      = in_unit[7:0];
  assign is_low = (in_unit >= 16'hDC00);

  always_comb begin
    trails_pending_next       = trails_pending;
    overlong_mask_next        = overlong_mask;
    range_check_armed_next    = range_check_armed;
    expect_low_surrogate_next = expect_low_surrogate;
    sticky_error_next         = sticky_error;

    if (sticky_error == ST_OK) begin
      if (!encoding_mode) begin
        if (trails_pending == 2'd0) begin
          if (b < LEAD_ASCII_END) begin
            // plain ASCII, nothing to track
          end else if (b < LEAD_MIN || b > LEAD_MAX) begin
            sticky_error_next = ST_BAD_LEAD;
          end else begin
            if (b < LEAD_3B) begin
              trails_pending_next = 2'd1;
            end else if (b < LEAD_4B) begin
              trails_pending_next = 2'd2;
            end else begin
              trails_pending_next = 2'd3;
            end
            overlong_mask_next = OVL_NONE;
            if ((b & OVL_LEAD_MASK) == LEAD_3B) begin
              overlong_mask_next = (b == LEAD_3B) ? OVL_NEED_20 : OVL_NEED_30;
            end
            range_check_armed_next = (b == LEAD_MAX);
          end
        end else if ((b & TRAIL_MASK) != TRAIL_TAG) begin
          sticky_error_next = ST_MISSING_TRAIL;
        end else begin
          case (overlong_mask)
            OVL_NEED_20: begin
              if ((b & BITS_20) == 8'h00) sticky_error_next = ST_OVERLONG;
              overlong_mask_next = OVL_NONE;
            end
            OVL_NEED_30: begin
              if ((b & BITS_30) == 8'h00) sticky_error_next = ST_OVERLONG;
              overlong_mask_next = OVL_NONE;
            end
            default: ;
          endcase
          if (sticky_error_next == ST_OK && range_check_armed) begin
            if ((b & BITS_30) != 8'h00) begin
              sticky_error_next = ST_ABOVE_MAX;
            end else begin
              range_check_armed_next = 1'b0;
            end
          end
          if (sticky_error_next == ST_OK) begin
            trails_pending_next = trails_pending - 2'd1;
          end
        end
      end else begin
        if (in_unit >= SURR_FIRST && in_unit <= SURR_LAST) begin
          if (is_low != expect_low_surrogate) begin
            sticky_error_next = ST_LONE_SURR;
          end else begin
            expect_low_surrogate_next = !is_low;
          end
        end else if (expect_low_surrogate) begin
          sticky_error_next = ST_UNPAIRED_LEAD;
        end
      end
    end

    // end-of-string check against what is still open
    if (in_last && sticky_error_next == ST_OK) begin
      if (!encoding_mode) begin
        if (trails_pending_next != 2'd0) sticky_error_next = ST_MISSING_TRAIL;
      end else if (expect_low_surrogate_next) begin
        sticky_error_next = ST_UNPAIRED_LEAD;
      end
    end

    result_status = sticky_error_next;

    if (in_last) begin
      trails_pending_next       = 2'd0;
      overlong_mask_next        = OVL_NONE;
      range_check_armed_next    = 1'b0;
      expect_low_surrogate_next = 1'b0;
      sticky_error_next         = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode        <= 1'b0;
      in_valid             <= 1'b0;
      out_valid            <= 1'b0;
      trails_pending       <= 2'd0;
      overlong_mask        <= OVL_NONE;
      range_check_armed    <= 1'b0;
      expect_low_surrogate <= 1'b0;
      sticky_error         <= ST_OK;
    end else begin
      if (cfg_valid && cfg_ready) encoding_mode <= cfg_data;
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (advance) begin
        out_valid            <= 1'b1;
        trails_pending       <= trails_pending_next;
        overlong_mask        <= overlong_mask_next;
        range_check_armed    <= range_check_armed_next;
        expect_low_surrogate <= expect_low_surrogate_next;
        sticky_error         <= sticky_error_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_unit <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance) begin
      out_status       <= result_status;
      out_string_valid <= in_last && (result_status == ST_OK);
      out_last         <= in_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'h0, out_string_valid, out_status};
  assign m_axis_tlast  = out_last;

endmodule
`default_nettype wire

// ===== design/utfsv_checker.sv =====
// Checker on the validator's result port, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "utf_stream_validator_defines.svh"
module utfsv_checker
  import utfsv_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tlast
);

  `UTFSV_ASSERT_IMP(a_valid_only_at_end, clk, rst, m_axis_tvalid && m_axis_tdata[3], m_axis_tlast, "string_valid set on a unit that does not close the string")
  `UTFSV_ASSERT_IMP(a_verdict_matches, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3] == (m_axis_tdata[2:0] == ST_OK), "verdict disagrees with status")
  `UTFSV_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid, m_axis_tdata[2:0] != 3'd7 && m_axis_tdata[7:4] == 4'h0, "status code out of range or pad bits set")
  `UTFSV_ASSERT_NXT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

endmodule

bind utf_stream_validator utfsv_checker u_utfsv_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
